// ===== hdl/scrp_pkg.sv =====
package scrp_pkg;

  // register file geometry
  localparam int unsigned RegCount = 42;
  localparam int unsigned AddrW    = $clog2(RegCount);

  // bus decode constants
  localparam logic [9:0] PairMask = 10'h3FE;
  localparam logic [9:0] BaseAlt  = 10'h370;
  localparam logic [9:0] BaseMain = 10'h3F0;

  // index port keys
  localparam logic [7:0] UnlockKey = 8'h55;
  localparam logic [7:0] LockKey   = 8'hAA;

  // highest index that reads back, and the byte of a read that misses
  localparam logic [7:0] ReadLast = 8'h29;
  localparam logic [7:0] IdleByte = 8'hFF;

  // unlock counter
  localparam logic [1:0] UnlockDone = 2'd2;

  // access kind
  localparam logic ModeRead  = 1'b0;
  localparam logic ModeWrite = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SEND = 2'b10
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic take;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;
  } status_t;

  // chip reset value of each configuration register
  function automatic logic [7:0] reset_value(input logic [7:0] idx);
    logic [7:0] val;
    case (idx)
      8'h00:   val = 8'h28;
      8'h01:   val = 8'h9C;
      8'h02:   val = 8'h88;
      8'h03:   val = 8'h78;
      8'h06:   val = 8'hFF;
      8'h0D:   val = 8'h03;
      8'h0E:   val = 8'h02;
      8'h1E:   val = 8'h3C;
      8'h20:   val = 8'h3C;
      8'h21:   val = 8'h3C;
      8'h22:   val = 8'h3D;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// ===== hdl/scrp_if.sv =====
interface scrp_req_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [9:0] port_address;
  logic [7:0] write_byte;

  modport source (output valid, output mode, output port_address, output write_byte,
                  input ready);
  modport sink (input valid, input mode, input port_address, input write_byte,
                output ready);
endinterface

interface scrp_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;

  modport source (output valid, output read_byte, input ready);
  modport sink (input valid, input read_byte, output ready);
endinterface

// ===== hdl/scrp_ctrl.sv =====
module scrp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              rsp_ready_i,
  input  scrp_pkg::status_t status_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  output scrp_pkg::cmd_t    cmd_o
);

  scrp_pkg::state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    cmd_o.take  = 1'b0;
    case (state_q)
      scrp_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.take = 1'b1;
          // a read leaves one result behind
          if (status_i.is_read) begin
            state_d = scrp_pkg::S_SEND;
          end
        end
      end
      scrp_pkg::S_SEND: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = scrp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = scrp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scrp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/scrp_dp.sv =====
module scrp_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  scrp_pkg::cmd_t    cmd_i,
  input  logic              mode_i,
  input  logic [9:0]        port_address_i,
  input  logic [7:0]        write_byte_i,
  output scrp_pkg::status_t status_o,
  output logic [7:0]        read_byte_o
);

  logic                          alt_base_q;
  logic [1:0]                    unlock_q;
  logic [7:0]                    index_q;
  logic [scrp_pkg::RegCount-1:0] written_q;
  logic [7:0]                    mem [scrp_pkg::RegCount];

  logic [7:0] rd_mem_q;
  logic [7:0] rd_rst_q;
  logic       rd_written_q;
  logic       rd_ok_q;

  logic [9:0]                 base;
  logic                       hit;
  logic                       data_port;
  logic                       unlocked;
  logic                       in_range;
  logic                       rd_ok;
  logic                       wr_reg;
  logic [scrp_pkg::AddrW-1:0] addr;

  assign base      = alt_base_q ? scrp_pkg::BaseAlt : scrp_pkg::BaseMain;
  assign hit       = (port_address_i & scrp_pkg::PairMask) == base;
  assign data_port = port_address_i[0];
  assign unlocked  = unlock_q == scrp_pkg::UnlockDone;
  assign in_range  = {1'b0, index_q} < 9'(scrp_pkg::RegCount);
  assign addr      = index_q[scrp_pkg::AddrW-1:0];
  assign rd_ok     = hit && data_port && unlocked && in_range
                     && (index_q <= scrp_pkg::ReadLast);
  assign wr_reg    = cmd_i.take && (mode_i == scrp_pkg::ModeWrite) && hit && data_port
                     && unlocked && in_range;

  assign status_o.is_read = mode_i == scrp_pkg::ModeRead;

  // base select, unlock state and index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_base_q <= 1'b0;
      unlock_q   <= '0;
      index_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        alt_base_q <= cfg_wdata_i;
      end
      if (cmd_i.take && (mode_i == scrp_pkg::ModeWrite) && hit && !data_port) begin
        if (write_byte_i == scrp_pkg::UnlockKey) begin
          if (!unlocked) begin
            unlock_q <= unlock_q + 2'd1;
          end
        end else if (write_byte_i == scrp_pkg::LockKey) begin
          unlock_q <= '0;
        end else if (unlocked) begin
          index_q <= write_byte_i;
        end
      end
    end
  end

  // written flags: an unwritten entry reads its chip reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_reg) begin
      written_q[addr] <= 1'b1;
    end
  end

  // register file
  always_ff @(posedge clk_i) begin
    if (wr_reg) begin
      mem[addr] <= write_byte_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      rd_mem_q     <= mem[addr];
      rd_rst_q     <= scrp_pkg::reset_value(index_q);
      rd_written_q <= written_q[addr];
      rd_ok_q      <= rd_ok;
    end
  end

  assign read_byte_o = !rd_ok_q    ? scrp_pkg::IdleByte :
                       rd_written_q ? rd_mem_q : rd_rst_q;

endmodule

// ===== hdl/superio_config_register_port_unit.sv =====
// Index/data configuration port of a super I/O chip. Each request is one bus
// access (mode 0 read, 1 write) at a ten-bit port address; only the pair at
// base 0x3F0, or 0x370 when alt_base_select is set, responds, the even port
// being the index port and the odd port the data port. Two writes of 0x55 to
// the index port open configuration mode and 0xAA closes it; while open, other
// index bytes set the register index, and data-port writes and reads go to a
// 42-entry register file that comes out of reset holding the chip defaults.
// A read returns exactly one response byte (0xFF when the port, mode or index
// does not allow the read); a write returns none. A write is done when it is
// accepted, and the next request can follow right behind it. In the accept
// cycle of a read the register file is read into the output register; the
// response then waits for rsp_o.ready, and no request is taken while a
// response is pending. alt_base_select is written through cfg_we_i and
// cfg_wdata_i and must only change while no request is in flight.
module superio_config_register_port_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  scrp_req_if.sink    req_i,
  scrp_rsp_if.source  rsp_o
);

  scrp_pkg::cmd_t    cmd;
  scrp_pkg::status_t status;

  // sequencing of the handshakes
  scrp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (status),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .cmd_o       (cmd)
  );

  // decode, unlock logic, register file and response register
  scrp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .mode_i         (req_i.mode),
    .port_address_i (req_i.port_address),
    .write_byte_i   (req_i.write_byte),
    .status_o       (status),
    .read_byte_o    (rsp_o.read_byte)
  );

endmodule

// ===== hdl/scrp_chk.sv =====
module scrp_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic req_mode_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i
);

  // a pending response holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped before it was taken");

  // no request slips in while a response waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(req_valid_i && req_ready_i))
    else $error("request accepted while a response is pending");

  // every accepted read answers in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_mode_i == scrp_pkg::ModeRead) |=> rsp_valid_i)
    else $error("read request without response");

  // a write never produces a response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_mode_i == scrp_pkg::ModeWrite) |=> !rsp_valid_i)
    else $error("write request produced a response");

endmodule

bind superio_config_register_port_unit scrp_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_mode_i  (req_i.mode),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready)
);
